/* hdl/adsm_pkg.sv */
// Shared types and constants for the ADC seven-segment display multiplexer.
// Used by the top level and by its port checker; depends on nothing else.
package adsm_pkg;

  // Number of display digits (thousands, hundreds, tens, units)
  localparam int unsigned DIGITS = 4;
  localparam int unsigned IDX_W  = $clog2(DIGITS);

  // Register widths and reset values
  localparam int unsigned REFRESH_W = 8;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned SWITCH_W  = 16;
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [REFRESH_W-1:0] REFRESH_RST = 8'd2;
  localparam logic [SAMPLE_W-1:0]  SAMPLE_RST  = 16'd500;
  localparam logic [SWITCH_W-1:0]  SWITCH_RST  = 16'd10;

  // Field widths
  localparam int unsigned VALUE_W = 10;
  localparam int unsigned SEG_W   = 7;
  localparam int unsigned BCD_W   = 4;

  // Stream data widths, padded to whole bytes
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REFRESH_TICKS  = 2'd0,
    REG_SAMPLE_TICKS   = 2'd1,
    REG_SWITCH_SAMPLES = 2'd2
  } cfg_reg_t;

  // Input kinds carried on in_tuser
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_SAMPLE = 1'b1;

  // Result request, last field in the lowest bits
  typedef struct packed {
    logic [1:0]       pad;
    logic             sample_channel;
    logic             sample_request;
    logic [SEG_W-1:0] segments;
    logic [DIGITS-1:0] digit_enable;
    logic             display_valid;
  } out_item_t;

  // Segment pattern of one BCD digit, bit0 a through bit6 g; 10..15 blank
  function automatic logic [SEG_W-1:0] seg_lut(input logic [BCD_W-1:0] d);
    logic [SEG_W-1:0] s;
    case (d)
      4'd0:    s = 7'h3F;
      4'd1:    s = 7'h06;
      4'd2:    s = 7'h5B;
      4'd3:    s = 7'h4F;
      4'd4:    s = 7'h66;
      4'd5:    s = 7'h6D;
      4'd6:    s = 7'h7D;
      4'd7:    s = 7'h07;
      4'd8:    s = 7'h7F;
      4'd9:    s = 7'h6F;
      default: s = 7'h00;
    endcase
    return s;
  endfunction

endpackage

/* hdl/adc_seven_segment_display_mux.sv */
// Top level of the ADC seven-segment display multiplexer and sample scheduler.
// Depends on adsm_pkg for widths, register indexes and the segment table.
//
// Usage:
//   in_*  : one request per accepted beat. in_tuser is the kind (0 timer tick,
//           1 ADC sample delivery); in_tdata[9:0] is the sample value.
//   out_* : one request per tick on which a digit refresh or a conversion
//           request happens; quiet ticks and sample deliveries give none.
//   cfg_* : register writes, taken at any edge with cfg_we high outside reset; a new
//           period takes effect at the next reload of its counter.
// Path: a result goes through the input register, then the result register.
// Throughput: one request per cycle unless a held result stalls the input
//   register; the only logic between the two registers is the counter update,
//   the segment lookup and a constant-multiply BCD split of the sample.
// Reset: counters load their reset periods, the digit store clears to zero,
//   the digit index starts at thousands and the channel at 1; both stream
//   stages empty.
// Stall: while out_tready is low a held result keeps its data; the input
//   register still fills once, then in_tready drops until the result is taken.
module adc_seven_segment_display_mux (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // Input stream
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  input  logic [adsm_pkg::IN_DATA_W-1:0]          in_tdata,  // [9:0] sample_value
  input  logic                                    in_tuser,  // [0] cmd
  // Result stream
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  // [0] display_valid, [4:1] digit_enable, [11:5] segments,
  // [12] sample_request, [13] sample_channel
  output logic [adsm_pkg::OUT_DATA_W-1:0]         out_tdata,
  // Configuration write port
  input  logic                                    cfg_we,
  input  logic [adsm_pkg::CFG_IDX_W-1:0]          cfg_addr,
  input  logic [adsm_pkg::CFG_W-1:0]              cfg_wdata
);

  // Configuration registers
  logic [adsm_pkg::REFRESH_W-1:0] refresh_ticks_r;
  logic [adsm_pkg::SAMPLE_W-1:0]  sample_ticks_r;
  logic [adsm_pkg::SWITCH_W-1:0]  switch_samples_r;

  // Input register
  logic                           s1_valid_r;
  logic                           s1_cmd_r;
  logic [adsm_pkg::VALUE_W-1:0]   s1_value_r;
  logic                           s1_go;

  // Block state
  logic [adsm_pkg::REFRESH_W-1:0] refresh_count_r, refresh_count_nxt;
  logic [adsm_pkg::SAMPLE_W-1:0]  sample_count_r, sample_count_nxt;
  logic [adsm_pkg::SWITCH_W-1:0]  switch_count_r, switch_count_nxt;
  logic [adsm_pkg::IDX_W-1:0]     digit_index_r, digit_index_nxt;
  logic [adsm_pkg::BCD_W-1:0]     digit_store_r [adsm_pkg::DIGITS];
  logic                           channel_r, channel_nxt;

  // Result register
  logic                           out_valid_r;
  adsm_pkg::out_item_t            out_data_r, out_data_nxt;
  logic                           emit;

  // BCD split of the sample
  logic                           bcd_thou;
  logic [adsm_pkg::VALUE_W-1:0]   bcd_r1;
  logic [15:0]                    bcd_h_prod;
  logic [adsm_pkg::BCD_W-1:0]     bcd_hund;
  logic [6:0]                     bcd_r2;
  logic [14:0]                    bcd_t_prod;
  logic [adsm_pkg::BCD_W-1:0]     bcd_tens;
  logic [adsm_pkg::BCD_W-1:0]     bcd_units;

  // Tick decode
  logic                           refresh_fire;
  logic                           sample_fire;
  logic                           switch_fire;
  logic                           tick;

  // Handshake: stage 1 moves on when the result register is free or emptying
  assign s1_go      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_go;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Configuration writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_ticks_r  <= adsm_pkg::REFRESH_RST;
      sample_ticks_r   <= adsm_pkg::SAMPLE_RST;
      switch_samples_r <= adsm_pkg::SWITCH_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        adsm_pkg::REG_REFRESH_TICKS:  refresh_ticks_r  <= cfg_wdata[adsm_pkg::REFRESH_W-1:0];
        adsm_pkg::REG_SAMPLE_TICKS:   sample_ticks_r   <= cfg_wdata[adsm_pkg::SAMPLE_W-1:0];
        adsm_pkg::REG_SWITCH_SAMPLES: switch_samples_r <= cfg_wdata[adsm_pkg::SWITCH_W-1:0];
        default: ;
      endcase
    end
  end

  // Capture the input request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_cmd_r   <= in_tuser;
      s1_value_r <= in_tdata[adsm_pkg::VALUE_W-1:0];
    end
  end

  // Split the sample into BCD digits by constant reciprocals
  always_comb begin
    bcd_thou   = (s1_value_r >= 10'd1000);
    bcd_r1     = bcd_thou ? (s1_value_r - 10'd1000) : s1_value_r;
    // x / 100 == (x * 41) >> 12 for x below 1000
    bcd_h_prod = {6'd0, bcd_r1} * 16'd41;
    bcd_hund   = bcd_h_prod[15:12];
    bcd_r2     = 7'(bcd_r1 - 10'({6'd0, bcd_hund} * 10'd100));
    // x / 10 == (x * 205) >> 11 for x below 100
    bcd_t_prod = {8'd0, bcd_r2} * 15'd205;
    bcd_tens   = bcd_t_prod[14:11];
    bcd_units  = 4'(bcd_r2 - 7'({3'd0, bcd_tens} * 7'd10));
  end

  // Count down the refresh and sample counters on a tick, and the channel counter on each sample request
  always_comb begin
    tick              = s1_go && (s1_cmd_r == adsm_pkg::CMD_TICK);
    refresh_fire      = (refresh_count_r <= 8'd1);
    sample_fire       = (sample_count_r <= 16'd1);
    switch_fire       = (switch_count_r <= 16'd1);

    refresh_count_nxt = refresh_fire ? refresh_ticks_r : (refresh_count_r - 8'd1);
    digit_index_nxt   = refresh_fire ? (digit_index_r + 2'd1) : digit_index_r;
    sample_count_nxt  = sample_fire ? sample_ticks_r : (sample_count_r - 16'd1);
    switch_count_nxt  = switch_count_r;
    channel_nxt       = channel_r;
    if (sample_fire) begin
      switch_count_nxt = switch_fire ? switch_samples_r : (switch_count_r - 16'd1);
      channel_nxt      = switch_fire ? !channel_r : channel_r;
    end

    // Build the result request; unused fields stay zero
    out_data_nxt = '0;
    if (refresh_fire) begin
      out_data_nxt.display_valid = 1'b1;
      out_data_nxt.digit_enable  = 4'b1000 >> digit_index_r;
      out_data_nxt.segments      = adsm_pkg::seg_lut(digit_store_r[digit_index_r]);
    end
    if (sample_fire) begin
      out_data_nxt.sample_request = 1'b1;
      out_data_nxt.sample_channel = channel_r;
    end
    emit = tick && (refresh_fire || sample_fire);
  end

  // Advance block state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      refresh_count_r <= adsm_pkg::REFRESH_RST;
      sample_count_r  <= adsm_pkg::SAMPLE_RST;
      switch_count_r  <= adsm_pkg::SWITCH_RST;
      digit_index_r   <= '0;
      channel_r       <= 1'b1;
    end else if (tick) begin
      refresh_count_r <= refresh_count_nxt;
      sample_count_r  <= sample_count_nxt;
      switch_count_r  <= switch_count_nxt;
      digit_index_r   <= digit_index_nxt;
      channel_r       <= channel_nxt;
    end
  end

  // Store the digits of a delivered sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < adsm_pkg::DIGITS; i++) begin
        digit_store_r[i] <= '0;
      end
    end else if (s1_go && (s1_cmd_r == adsm_pkg::CMD_SAMPLE)) begin
      digit_store_r[0] <= {3'd0, bcd_thou};
      digit_store_r[1] <= bcd_hund;
      digit_store_r[2] <= bcd_tens;
      digit_store_r[3] <= bcd_units;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

endmodule

/* hdl/adsm_checker.sv */
// Port-level checker for the ADC seven-segment display multiplexer.
// Depends on adsm_pkg for the result layout; bound to the top level below.
module adsm_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [adsm_pkg::OUT_DATA_W-1:0] out_tdata
);

  adsm_pkg::out_item_t o;
  assign o = out_tdata;

  // Hold a stalled result
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Every result carries a refresh or a request
  a_event: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> o.display_valid || o.sample_request)
    else $error("result without an event");

  // A refresh drives exactly one digit
  a_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && o.display_valid |-> $onehot(o.digit_enable))
    else $error("digit select not one-hot");

  // Display fields are zero without a refresh
  a_blank: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !o.display_valid |-> o.digit_enable == '0 && o.segments == '0)
    else $error("display fields set without a refresh");

  // Channel is zero without a request
  a_chan: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !o.sample_request |-> !o.sample_channel)
    else $error("channel set without a request");

endmodule

bind adc_seven_segment_display_mux adsm_checker u_adsm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
